// ----- hw/rtl/fin_mix_second_order_actuator_defines.svh -----
// assertion macros used by the checker
`ifndef FIN_MIX_SECOND_ORDER_ACTUATOR_DEFINES_SVH
`define FIN_MIX_SECOND_ORDER_ACTUATOR_DEFINES_SVH

// property checked outside reset
`define FMSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define FMSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fmsa_pkg.sv -----
package fmsa_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_DEFL  = 3'd0;
    localparam logic [2:0] CFG_QSTEP     = 3'd1;
    localparam logic [2:0] CFG_OMEGA_SQ  = 3'd2;
    localparam logic [2:0] CFG_DAMPING   = 3'd3;
    localparam logic [2:0] CFG_HALF_STEP = 3'd4;

    localparam int NUM_FINS = 4;

    // reset values of the configuration registers
    localparam logic [14:0] RST_MAX_DEFL  = 15'd1792;
    localparam logic [12:0] RST_QSTEP     = 13'd32;
    localparam logic [31:0] RST_OMEGA_SQ  = 32'd16170360;
    localparam logic [23:0] RST_DAMPING   = 24'd90076;
    localparam logic [31:0] RST_HALF_STEP = 32'd2147484;

    typedef struct packed {
        logic signed [15:0] roll_cmd;
        logic signed [15:0] pitch_cmd;
        logic signed [15:0] yaw_cmd;
    } t_in;

    typedef struct packed {
        logic signed [15:0] fin1_deflection;
        logic signed [15:0] fin2_deflection;
        logic signed [15:0] fin3_deflection;
        logic signed [15:0] fin4_deflection;
        logic               was_limited;
    } t_out;

    // saturate a 64-bit signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sh0000_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // saturate a 64-bit signed value to 40 bits
    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        logic signed [39:0] r;
        if (v > 64'sh0000_007F_FFFF_FFFF) begin
            r = 40'sh7F_FFFF_FFFF;
        end else if (v < -64'sh0000_0080_0000_0000) begin
            r = 40'sh80_0000_0000;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // position divided by 256 toward zero, saturated to 16 bits
    function automatic logic signed [15:0] pos_to_out(input logic signed [31:0] p);
        logic signed [32:0] b;
        logic signed [24:0] q;
        logic signed [15:0] r;
        b = 33'(p) + (p[31] ? 33'sd255 : 33'sd0);
        q = 25'(b >>> 8);
        if (q > 25'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -25'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/fin_mix_second_order_actuator.sv -----
// channel | signals                         | item
// --------+---------------------------------+----------------------------------
// input   | i_valid, o_ready, i_in          | roll, pitch, yaw commands
// output  | o_valid, i_ready, o_out         | four fin positions, limit flag
// config  | i_cfg_we, i_cfg_idx, i_cfg_data | one register write, no wait
//
// each item runs through the fins in turn before ready returns: per fin an
// 18-step quantising divide and four multiply passes on the shared unit,
// plus a 15-step scaling divide before them when limited
// ready only in idle
// one finished item can wait in the output register while the next item is
// taken; a result still waiting at hand-off holds the sequencer there
// reset is synchronous, active low, clears state and restores the registers
module fin_mix_second_order_actuator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fmsa_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output fmsa_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MIX, S_SC_MUL, S_SC_LD, S_Q_LD, S_DIV, S_Q_MUL, S_Q_FIN,
        S_M_ABS, S_M_LO, S_M_HI, S_M_ACC, S_M_FIN, S_USE, S_DONE
    } t_state;

    typedef enum logic [1:0] {OP_POS, OP_ERR, OP_DAMP, OP_RATE} t_op;

    // configuration
    logic [14:0] r_max_defl;
    logic [12:0] r_qstep;
    logic [31:0] r_omega_sq;
    logic [23:0] r_damping;
    logic [31:0] r_half_step;

    // sequencer
    t_state r_state;
    t_op    r_op;
    logic [1:0] r_fin;
    logic       r_lim;
    logic [16:0] r_peak;
    logic signed [17:0] r_cmd [fmsa_pkg::NUM_FINS];

    // divider
    logic [16:0] r_rem;
    logic [17:0] r_dq;
    logic [16:0] r_div_d;
    logic [4:0]  r_cnt;
    logic        r_div_scale;

    // shared multiplier
    logic [63:0] r_prod;
    logic [80:0] r_acc;
    logic [48:0] r_mag;
    logic [31:0] r_mb;
    logic        r_s32;
    logic        r_neg;
    logic signed [63:0] r_opa;
    logic signed [63:0] r_mres;
    logic signed [63:0] r_t;
    logic signed [39:0] r_qcmd;
    logic signed [47:0] r_accel;

    // fin state
    logic signed [31:0] r_pos    [fmsa_pkg::NUM_FINS];
    logic signed [39:0] r_rate   [fmsa_pkg::NUM_FINS];
    logic signed [39:0] r_prate  [fmsa_pkg::NUM_FINS];
    logic signed [47:0] r_paccel [fmsa_pkg::NUM_FINS];
    logic signed [15:0] r_res    [fmsa_pkg::NUM_FINS];

    logic           r_ovalid;
    fmsa_pkg::t_out r_out;

    // combinational helpers
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic signed [17:0] w_c;
    logic [16:0] w_cabs;
    logic [12:0] w_step;
    logic [16:0] w_qmag;
    logic [17:0] w_qdiv;
    logic [17:0] w_rem_sh;
    logic        w_ge;
    logic [17:0] w_rem_sub;
    logic [16:0] w_abs [fmsa_pkg::NUM_FINS];
    logic [16:0] w_pk01;
    logic [16:0] w_pk23;
    logic [80:0] w_shifted;
    logic [62:0] w_mclip;
    logic signed [63:0] w_mag_src;
    logic signed [31:0] w_pos;
    logic signed [47:0] w_accel;
    logic signed [17:0] w_r;
    logic signed [17:0] w_p;
    logic signed [17:0] w_y;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    // mixing inputs
    assign w_r = 18'(i_in.roll_cmd);
    assign w_p = 18'(i_in.pitch_cmd);
    assign w_y = 18'(i_in.yaw_cmd);

    // peak magnitude of the four commands
    always_comb begin
        for (int k = 0; k < fmsa_pkg::NUM_FINS; k++) begin
            w_abs[k] = r_cmd[k][17] ? 17'(-r_cmd[k]) : 17'(r_cmd[k]);
        end
        w_pk01 = (w_abs[0] > w_abs[1]) ? w_abs[0] : w_abs[1];
        w_pk23 = (w_abs[2] > w_abs[3]) ? w_abs[2] : w_abs[3];
    end

    // current fin command and quantizer operands
    assign w_c    = r_cmd[r_fin];
    assign w_cabs = w_abs[r_fin];
    assign w_step = (r_qstep == 13'd0) ? 13'd1 : r_qstep;
    assign w_qmag = r_lim ? {2'b0, r_dq[14:0]} : w_cabs;
    assign w_qdiv = {w_qmag, 1'b0} + 18'(w_step);

    // restoring divide step
    assign w_rem_sh  = {r_rem, r_dq[17]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div_d});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div_d};

    // shared multiplier operand selection
    always_comb begin
        case (r_state)
            S_SC_MUL: begin
                w_ma = 32'(w_cabs);
                w_mb = 32'(r_max_defl);
            end
            S_Q_MUL: begin
                w_ma = 32'(r_dq[16:0]);
                w_mb = 32'(w_step);
            end
            S_M_HI: begin
                w_ma = 32'(r_mag[48:32]);
                w_mb = r_mb;
            end
            default: begin
                w_ma = r_mag[31:0];
                w_mb = r_mb;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // product shift and clip to 2^62
    assign w_shifted = r_s32 ? (r_acc >> 32) : (r_acc >> 8);
    assign w_mclip   = (w_shifted > (81'd1 << 62)) ? (63'd1 << 62) : w_shifted[62:0];
    assign w_mag_src = r_opa[63] ? -r_opa : r_opa;

    // fin update results
    assign w_pos   = fmsa_pkg::sat32(64'(r_pos[r_fin]) + r_mres);
    assign w_accel = fmsa_pkg::sat48(r_t - r_mres);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_defl  <= fmsa_pkg::RST_MAX_DEFL;
            r_qstep     <= fmsa_pkg::RST_QSTEP;
            r_omega_sq  <= fmsa_pkg::RST_OMEGA_SQ;
            r_damping   <= fmsa_pkg::RST_DAMPING;
            r_half_step <= fmsa_pkg::RST_HALF_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fmsa_pkg::CFG_MAX_DEFL:  r_max_defl  <= i_cfg_data[14:0];
                fmsa_pkg::CFG_QSTEP:     r_qstep     <= i_cfg_data[12:0];
                fmsa_pkg::CFG_OMEGA_SQ:  r_omega_sq  <= i_cfg_data;
                fmsa_pkg::CFG_DAMPING:   r_damping   <= i_cfg_data[23:0];
                fmsa_pkg::CFG_HALF_STEP: r_half_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, datapath and fin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_POS;
            r_fin    <= 2'd0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < fmsa_pkg::NUM_FINS; k++) begin
                r_pos[k]    <= '0;
                r_rate[k]   <= '0;
                r_prate[k]  <= '0;
                r_paccel[k] <= '0;
            end
        end else begin
            // hand-off in S_DONE sets the flag again itself
            if (r_ovalid && i_ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                // mix the commands of the accepted item
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd[0] <= -w_p + w_y + w_r;
                        r_cmd[1] <= -w_p - w_y + w_r;
                        r_cmd[2] <= w_p - w_y + w_r;
                        r_cmd[3] <= w_p + w_y + w_r;
                        r_fin    <= 2'd0;
                        r_state  <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_peak  <= (w_pk01 > w_pk23) ? w_pk01 : w_pk23;
                    r_lim   <= (((w_pk01 > w_pk23) ? w_pk01 : w_pk23) > {2'b0, r_max_defl});
                    r_state <= S_SC_MUL;
                end
                // scale to the maximum deflection
                S_SC_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= r_lim ? S_SC_LD : S_Q_LD;
                end
                S_SC_LD: begin
                    r_rem       <= r_prod[31:15];
                    r_dq        <= {r_prod[14:0], 3'b0};
                    r_div_d     <= r_peak;
                    r_cnt       <= 5'd15;
                    r_div_scale <= 1'b1;
                    r_state     <= S_DIV;
                end
                // quantize: (2 mag + step) / (2 step)
                S_Q_LD: begin
                    r_rem       <= '0;
                    r_dq        <= w_qdiv;
                    r_div_d     <= {3'b0, w_step, 1'b0};
                    r_cnt       <= 5'd18;
                    r_div_scale <= 1'b0;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_rem_sub[16:0] : w_rem_sh[16:0];
                    r_dq  <= {r_dq[16:0], w_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= r_div_scale ? S_Q_LD : S_Q_MUL;
                    end
                end
                S_Q_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_Q_FIN;
                end
                S_Q_FIN: begin
                    r_qcmd  <= w_c[17] ? -{2'b0, r_prod[29:0], 8'b0}
                                       : {2'b0, r_prod[29:0], 8'b0};
                    r_opa   <= 64'(r_rate[r_fin]) + 64'(r_prate[r_fin]);
                    r_mb    <= r_half_step;
                    r_s32   <= 1'b1;
                    r_op    <= OP_POS;
                    r_state <= S_M_ABS;
                end
                // multiply pass on the shared unit
                S_M_ABS: begin
                    r_neg   <= r_opa[63];
                    r_mag   <= 49'(w_mag_src);
                    r_state <= S_M_LO;
                end
                S_M_LO: begin
                    r_prod  <= w_prod;
                    r_state <= S_M_HI;
                end
                S_M_HI: begin
                    r_acc   <= 81'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_M_ACC;
                end
                S_M_ACC: begin
                    r_acc   <= r_acc + 81'({r_prod, 32'b0});
                    r_state <= S_M_FIN;
                end
                S_M_FIN: begin
                    r_mres  <= r_neg ? -64'(w_mclip) : 64'(w_mclip);
                    r_state <= S_USE;
                end
                // consume the product
                S_USE: begin
                    r_state <= S_M_ABS;
                    case (r_op)
                        OP_POS: begin
                            r_pos[r_fin]   <= w_pos;
                            r_prate[r_fin] <= r_rate[r_fin];
                            r_res[r_fin]   <= fmsa_pkg::pos_to_out(w_pos);
                            r_opa          <= 64'(r_qcmd) - 64'(w_pos);
                            r_mb           <= r_omega_sq;
                            r_s32          <= 1'b0;
                            r_op           <= OP_ERR;
                        end
                        OP_ERR: begin
                            r_t   <= r_mres;
                            r_opa <= 64'(r_rate[r_fin]);
                            r_mb  <= 32'(r_damping);
                            r_op  <= OP_DAMP;
                        end
                        OP_DAMP: begin
                            r_accel <= w_accel;
                            r_opa   <= 64'(w_accel) + 64'(r_paccel[r_fin]);
                            r_mb    <= r_half_step;
                            r_s32   <= 1'b1;
                            r_op    <= OP_RATE;
                        end
                        OP_RATE: begin
                            r_rate[r_fin]   <= fmsa_pkg::sat40(64'(r_rate[r_fin]) + r_mres);
                            r_paccel[r_fin] <= r_accel;
                            if (r_fin == 2'd3) begin
                                r_state <= S_DONE;
                            end else begin
                                r_fin   <= r_fin + 2'd1;
                                r_state <= S_SC_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
                // hand the item to the output register
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_out.fin1_deflection <= r_res[0];
                        r_out.fin2_deflection <= r_res[1];
                        r_out.fin3_deflection <= r_res[2];
                        r_out.fin4_deflection <= r_res[3];
                        r_out.was_limited     <= r_lim;
                        r_ovalid              <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/fmsa_checker.sv -----
`include "fin_mix_second_order_actuator_defines.svh"

module fmsa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input fmsa_pkg::t_in  i_in,
    input logic           o_valid,
    input logic           i_ready,
    input fmsa_pkg::t_out o_out
);

    // stalled result holds
    `FMSA_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_out), "result changed while stalled")

    // an accepted item keeps the block busy
    `FMSA_ASSERT(a_busy_after_accept, i_valid && o_ready |=> !o_ready, "ready after accepting an item")

    // no result appears in the cycle after an accept
    `FMSA_ASSERT(a_no_instant_result, i_valid && o_ready |=> !$rose(o_valid), "result too early")

    // no result just after reset
    `FMSA_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind fin_mix_second_order_actuator fmsa_checker u_fmsa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);
